// ===== hdl/sjf_pkg.sv =====
// Shared types and codes for the two-level thread scheduler
`default_nettype none
package sjf_pkg;
	localparam int TID_W = 4;
	localparam int BUD_W = 17;

	typedef enum logic [1:0] {
		OP_CREATE = 2'd0,
		OP_TICK   = 2'd1,
		OP_EXIT   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_IDLE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_PREEMPT = 3'd1,
		EV_QUANTUM = 3'd2,
		EV_FINISH  = 3'd3,
		EV_EJECT   = 3'd4
	} event_t;

	typedef enum logic [1:0] {
		CFG_QUANTUM = 2'd0,
		CFG_INIT    = 2'd1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		FSM_IDLE  = 2'd0,
		FSM_WORK  = 2'd1,
		FSM_OUT   = 2'd2
	} fsm_t;

	// command to every cell of a queue chain for one cycle
	typedef struct packed {
		logic push;      // insert tail/sorted entry
		logic pop;       // shift towards head
		logic sorted;    // high queue: insert by key
	} qcmd_t;
endpackage
`default_nettype wire

// ===== hdl/sjf_cell.sv =====
// One queue cell: holds an id and key, shifts towards the head or opens a gap for an insert
`default_nettype none
module sjf_cell #(
	parameter int IW = 4,
	parameter int KW = 17
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire sjf_pkg::qcmd_t       cmd,
	input  wire logic                 ins_here_tail,
	input  wire logic [IW-1:0]        new_id,
	input  wire logic signed [KW-1:0] new_key,
	input  wire logic                 prev_valid,
	input  wire logic [IW-1:0]        prev_id,
	input  wire logic signed [KW-1:0] prev_key,
	input  wire logic                 prev_goes_right,
	input  wire logic                 next_valid,
	input  wire logic [IW-1:0]        next_id,
	input  wire logic signed [KW-1:0] next_key,
	output logic                      valid,
	output logic [IW-1:0]             id,
	output logic signed [KW-1:0]      key,
	output logic                      goes_right
);
	import sjf_pkg::*;

	logic                 valid_q;
	logic [IW-1:0]        id_q;
	logic signed [KW-1:0] key_q;

	// entry moves right when a sorted insert lands before it
	assign goes_right = valid_q && cmd.sorted && (key_q > new_key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.pop) begin
			valid_q <= next_valid;
			id_q    <= next_id;
			key_q   <= next_key;
		end else if (cmd.push) begin
			if (cmd.sorted) begin
				if (goes_right) begin
					valid_q <= 1'b1;
					if (prev_goes_right) begin
						id_q  <= prev_id;
						key_q <= prev_key;
					end else begin
						id_q  <= new_id;
						key_q <= new_key;
					end
				end else if (!valid_q && prev_valid) begin
					valid_q <= 1'b1;
					if (prev_goes_right) begin
						id_q  <= prev_id;
						key_q <= prev_key;
					end else begin
						id_q  <= new_id;
						key_q <= new_key;
					end
				end else if (!valid_q && ins_here_tail) begin
					valid_q <= 1'b1;
					id_q    <= new_id;
					key_q   <= new_key;
				end
			end else if (ins_here_tail) begin
				valid_q <= 1'b1;
				id_q    <= new_id;
				key_q   <= new_key;
			end
		end
	end

	assign valid = valid_q;
	assign id    = id_q;
	assign key   = key_q;
endmodule
`default_nettype wire

// ===== hdl/sjf_queue.sv =====
// Row of queue cells: FIFO or key-sorted queue with head pop
`default_nettype none
module sjf_queue #(
	parameter int DEPTH = 16,
	parameter int IW    = 4,
	parameter int KW    = 17
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire sjf_pkg::qcmd_t       cmd,
	input  wire logic [IW-1:0]        new_id,
	input  wire logic signed [KW-1:0] new_key,
	output logic                      head_valid,
	output logic [IW-1:0]             head_id
);
	import sjf_pkg::*;

	logic                 v  [DEPTH];
	logic [IW-1:0]        ids[DEPTH];
	logic signed [KW-1:0] ks [DEPTH];
	logic                 gr [DEPTH];

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic                 pv, pg, nv, tail;
		logic [IW-1:0]        pid, nid;
		logic signed [KW-1:0] pk, nk;
		if (g == 0) begin : g_first
			assign pv   = 1'b0;
			assign pg   = 1'b0;
			assign pid  = '0;
			assign pk   = '0;
			assign tail = !v[0];
		end else begin : g_mid
			assign pv   = v[g-1];
			assign pg   = gr[g-1];
			assign pid  = ids[g-1];
			assign pk   = ks[g-1];
			assign tail = !v[g] && v[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign nv  = 1'b0;
			assign nid = '0;
			assign nk  = '0;
		end else begin : g_inner
			assign nv  = v[g+1];
			assign nid = ids[g+1];
			assign nk  = ks[g+1];
		end
		sjf_cell #(.IW(IW), .KW(KW)) u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(cmd), .ins_here_tail(tail),
			.new_id(new_id), .new_key(new_key),
			.prev_valid(pv), .prev_id(pid), .prev_key(pk), .prev_goes_right(pg),
			.next_valid(nv), .next_id(nid), .next_key(nk),
			.valid(v[g]), .id(ids[g]), .key(ks[g]), .goes_right(gr[g])
		);
	end

	assign head_valid = v[0];
	assign head_id    = ids[0];
endmodule
`default_nettype wire

// ===== hdl/sjf_rr_thread_scheduler_top.sv =====
// Top level of the two-level thread scheduler
// Sequence: an event is decoded on acceptance, then the work state does the
// optional second queue push and then the dispatch pop; output is registered.
// One event at a time: a new one is taken the cycle after the result is taken.
// Queues are rows of shifting cells, one insert or pop per cycle each.
// Reset: slot zero holds the running thread with initial_budget, queues empty.
`default_nettype none
module sjf_rr_thread_scheduler_top #(
	parameter int MAX_THREADS = 16,
	parameter int TICK_BITS   = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [1:0]                 op,
	input  wire logic                       priority_req,
	input  wire logic [TICK_BITS-1:0]       budget_ticks,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [1:0]                      status,
	output logic [$clog2(MAX_THREADS)-1:0]  created_tid,
	output logic [$clog2(MAX_THREADS)-1:0]  running_tid,
	output logic                            running_valid,
	output logic [2:0]                      event_code,
	output logic [$clog2(MAX_THREADS)-1:0]  ended_tid,
	input  wire logic                       cfg_we,
	input  wire logic [1:0]                 cfg_index,
	input  wire logic [TICK_BITS-1:0]       cfg_data
);
	import sjf_pkg::*;

	localparam int TW = $clog2(MAX_THREADS);
	localparam int BW = TICK_BITS + 1;

	logic [TICK_BITS-1:0] quantum_q, init_q, slice_q;
	logic                 started_q;
	logic [MAX_THREADS-1:0] used_q, prio_q;
	logic signed [BW-1:0] budget_q [MAX_THREADS];
	logic [TW-1:0]        cur_q;
	logic                 curv_q;
	fsm_t                 state_q, state_d;

	// per-event registers
	logic [TW-1:0]        pend_id_q;       // second push, if any
	logic                 pend_hi_q, pend_push_q, need_disp_q;
	logic [1:0]           st_q;
	logic [TW-1:0]        crt_q, end_q;
	logic [2:0]           ev_q;

	qcmd_t                lo_cmd, hi_cmd;
	logic [TW-1:0]        lo_id, hi_id;
	logic signed [BW-1:0] hi_key;
	logic                 lo_hv, hi_hv;
	logic [TW-1:0]        lo_hid, hi_hid;

	sjf_queue #(.DEPTH(MAX_THREADS), .IW(TW), .KW(BW)) u_low (
		.clk(clk), .arst_n(arst_n), .cmd(lo_cmd), .new_id(lo_id), .new_key('0),
		.head_valid(lo_hv), .head_id(lo_hid)
	);
	sjf_queue #(.DEPTH(MAX_THREADS), .IW(TW), .KW(BW)) u_high (
		.clk(clk), .arst_n(arst_n), .cmd(hi_cmd), .new_id(hi_id), .new_key(hi_key),
		.head_valid(hi_hv), .head_id(hi_hid)
	);

	logic [TICK_BITS-1:0] effq;
	assign effq = (quantum_q == '0) ? TICK_BITS'(1) : quantum_q;

	// free slot search
	logic          has_free;
	logic [TW-1:0] free_id;
	always_comb begin
		has_free = 1'b0;
		free_id  = '0;
		for (int i = MAX_THREADS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				has_free = 1'b1;
				free_id  = TW'(i);
			end
		end
	end

	logic accept;
	assign in_ready = (state_q == FSM_IDLE);
	assign accept   = in_valid && in_ready;

	logic signed [BW-1:0] cur_bud, cur_dec, new_bud;
	assign cur_bud = budget_q[cur_q];
	assign cur_dec = cur_bud - BW'(1);
	assign new_bud = $signed({1'b0, budget_ticks});

	// queue command in the work state: pending push first, then dispatch pop
	logic do_push, do_pop;
	always_comb begin
		state_d = state_q;
		do_push = 1'b0;
		do_pop  = 1'b0;
		case (state_q)
			FSM_IDLE: if (accept) state_d = FSM_WORK;
			FSM_WORK: begin
				if (pend_push_q) begin
					do_push = 1'b1;
				end else begin
					do_pop  = need_disp_q;
					state_d = FSM_OUT;
				end
			end
			FSM_OUT:  if (out_ready) state_d = FSM_IDLE;
			default:  state_d = FSM_IDLE;
		endcase
	end

	logic pop_hi, pop_lo;
	assign pop_hi = do_pop && hi_hv;
	assign pop_lo = do_pop && !hi_hv && lo_hv;

	always_comb begin
		lo_cmd = '{push: do_push && !pend_hi_q, pop: pop_lo, sorted: 1'b0};
		hi_cmd = '{push: do_push && pend_hi_q, pop: pop_hi, sorted: do_push && pend_hi_q};
		lo_id  = pend_id_q;
		hi_id  = pend_id_q;
		hi_key = budget_q[pend_id_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q   <= TICK_BITS'(10);
			init_q      <= '0;
			slice_q     <= TICK_BITS'(10);
			started_q   <= 1'b0;
			used_q      <= MAX_THREADS'(1);
			prio_q      <= '0;
			for (int i = 0; i < MAX_THREADS; i++) budget_q[i] <= '0;
			cur_q       <= '0;
			curv_q      <= 1'b1;
			pend_push_q <= 1'b0;
			need_disp_q <= 1'b0;
			pend_hi_q   <= 1'b0;
			pend_id_q   <= '0;
			st_q        <= ST_OK;
			crt_q       <= '0;
			end_q       <= '0;
			ev_q        <= EV_NONE;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_QUANTUM) begin
					quantum_q <= cfg_data;
					if (!started_q)
						slice_q <= (cfg_data == '0) ? TICK_BITS'(1) : cfg_data;
				end else if (cfg_index == CFG_INIT) begin
					init_q <= cfg_data;
					if (!started_q) budget_q[0] <= $signed({1'b0, cfg_data});
				end
			end
			if (accept) begin
				started_q   <= 1'b1;
				st_q        <= ST_OK;
				crt_q       <= '0;
				end_q       <= '0;
				ev_q        <= EV_NONE;
				pend_push_q <= 1'b0;
				need_disp_q <= 1'b0;
				case (op)
					OP_CREATE: begin
						if (!has_free) begin
							st_q <= ST_FULL;
						end else begin
							used_q[free_id]   <= 1'b1;
							prio_q[free_id]   <= priority_req;
							budget_q[free_id] <= new_bud;
							crt_q             <= free_id;
							if (!curv_q) begin
								pend_push_q <= 1'b1;
								pend_id_q   <= free_id;
								pend_hi_q   <= priority_req;
								need_disp_q <= 1'b1;
							end else if (!priority_req) begin
								pend_push_q <= 1'b1;
								pend_id_q   <= free_id;
								pend_hi_q   <= 1'b0;
							end else if (!prio_q[cur_q] || (new_bud < cur_bud)) begin
								pend_push_q <= 1'b1;
								pend_id_q   <= cur_q;
								pend_hi_q   <= prio_q[cur_q];
								cur_q       <= free_id;
								slice_q     <= effq;
								ev_q        <= EV_PREEMPT;
							end else begin
								pend_push_q <= 1'b1;
								pend_id_q   <= free_id;
								pend_hi_q   <= 1'b1;
							end
						end
					end
					OP_TICK: begin
						if (curv_q) begin
							budget_q[cur_q] <= cur_dec;
							if (!prio_q[cur_q] && slice_q != '0)
								slice_q <= slice_q - TICK_BITS'(1);
							if (cur_dec < 0) begin
								used_q[cur_q] <= 1'b0;
								end_q         <= cur_q;
								ev_q          <= EV_EJECT;
								need_disp_q   <= 1'b1;
							end else if (!prio_q[cur_q] && slice_q <= TICK_BITS'(1)) begin
								pend_push_q <= 1'b1;
								pend_id_q   <= cur_q;
								pend_hi_q   <= 1'b0;
								ev_q        <= EV_QUANTUM;
								need_disp_q <= 1'b1;
							end
						end
					end
					OP_EXIT: begin
						if (curv_q) begin
							used_q[cur_q] <= 1'b0;
							end_q         <= cur_q;
							ev_q          <= EV_FINISH;
							need_disp_q   <= 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (do_push) pend_push_q <= 1'b0;
			if (do_pop) begin
				if (hi_hv) begin
					cur_q   <= hi_hid;
					curv_q  <= 1'b1;
					slice_q <= effq;
				end else if (lo_hv) begin
					cur_q   <= lo_hid;
					curv_q  <= 1'b1;
					slice_q <= effq;
				end else begin
					cur_q  <= '0;
					curv_q <= 1'b0;
				end
			end
		end
	end

	assign out_valid     = (state_q == FSM_OUT);
	assign status        = (st_q == ST_FULL) ? ST_FULL : (curv_q ? ST_OK : ST_IDLE);
	assign created_tid   = crt_q;
	assign running_tid   = curv_q ? cur_q : '0;
	assign running_valid = curv_q;
	assign event_code    = ev_q;
	assign ended_tid     = end_q;

	// init_q is held for visibility of the register only
	logic unused_init;
	assign unused_init = ^init_q;

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		!(do_push && do_pop))
		else $error("push and pop in one cycle");
	a_out_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == FSM_WORK))
		else $error("result without work cycle");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != FSM_IDLE) |-> !in_ready)
		else $error("accept while busy");
	a_idle_tid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !running_valid) |-> (running_tid == '0))
		else $error("idle with tid");
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the two-level SJF / round-robin thread scheduler
`timescale 1ns / 1ps
module testbench;
	import sjf_pkg::*;

	localparam int NSLOT = 16;
	localparam int STALL_LIMIT = 5000;

	typedef struct packed {
		status_t    status;
		logic [3:0] created_tid;
		logic [3:0] running_tid;
		logic       running_valid;
		event_t     event_code;
		logic [3:0] ended_tid;
	} sched_result_t;

	typedef struct {
		logic [1:0]    op;
		logic          prio;
		logic [15:0]   budget;
		bit            typed;
		sched_result_t res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] op = '0;
	logic priority_req = 1'b0;
	logic [15:0] budget_ticks = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic [3:0] created_tid, running_tid, ended_tid;
	logic running_valid;
	logic [2:0] event_code;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	sjf_rr_thread_scheduler_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .priority_req(priority_req), .budget_ticks(budget_ticks),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .created_tid(created_tid), .running_tid(running_tid),
		.running_valid(running_valid), .event_code(event_code), .ended_tid(ended_tid),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// scheduler shadow state
	logic [15:0] quantum_reg, init_budget_reg;
	bit          slot_used [NSLOT];
	bit          slot_hi [NSLOT];
	int          slot_bud [NSLOT];
	int          run_tid;
	bit          run_valid;
	int          slice_left;
	int          low_q[$];
	int          high_ids[$];
	int          high_keys[$];
	bit          any_event;

	sched_result_t pending_results[$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;
	int n_events = 0, n_results = 0, n_preempt = 0, n_eject = 0, n_quantum = 0;
	int n_full = 0, n_idle = 0;

	function automatic int eff_quantum();
		return (quantum_reg == 0) ? 1 : int'(quantum_reg);
	endfunction

	function automatic void high_insert(int tid);
		int pos;
		pos = 0;
		if (high_ids.size() >= NSLOT)
			return;
		while (pos < high_ids.size() && high_keys[pos] <= slot_bud[tid])
			pos++;
		high_ids.insert(pos, tid);
		high_keys.insert(pos, slot_bud[tid]);
	endfunction

	function automatic void low_push(int tid);
		if (low_q.size() < NSLOT)
			low_q.push_back(tid);
	endfunction

	function automatic void start_thread(int tid);
		run_tid = tid;
		run_valid = 1;
		slice_left = eff_quantum();
	endfunction

	function automatic void pick_next();
		if (high_ids.size() > 0) begin
			void'(high_keys.pop_front());
			start_thread(high_ids.pop_front());
		end else if (low_q.size() > 0) begin
			start_thread(low_q.pop_front());
		end else begin
			run_valid = 0;
			run_tid = 0;
		end
	endfunction

	function automatic void reset_shadow();
		quantum_reg = 16'd10;
		init_budget_reg = 16'd0;
		for (int i = 0; i < NSLOT; i++) begin
			slot_used[i] = 0;
			slot_hi[i] = 0;
			slot_bud[i] = 0;
		end
		slot_used[0] = 1;
		run_tid = 0;
		run_valid = 1;
		slice_left = eff_quantum();
		low_q.delete();
		high_ids.delete();
		high_keys.delete();
		any_event = 0;
	endfunction

	function automatic void shadow_cfg(cfg_idx_t idx, logic [15:0] val);
		if (idx == CFG_QUANTUM) begin
			quantum_reg = val;
			if (!any_event)
				slice_left = eff_quantum();
		end else if (idx == CFG_INIT) begin
			init_budget_reg = val;
			if (!any_event)
				slot_bud[0] = int'(val);
		end
	endfunction

	function automatic sched_result_t schedule_event(logic [1:0] o, logic p, logic [15:0] b);
		sched_result_t r;
		int free_slot, cur;
		r = '0;
		r.status = ST_OK;
		r.event_code = EV_NONE;
		any_event = 1;
		cur = run_tid;
		if (o == OP_CREATE) begin
			free_slot = -1;
			for (int i = 0; i < NSLOT; i++)
				if (!slot_used[i] && free_slot < 0)
					free_slot = i;
			if (free_slot < 0) begin
				r.status = ST_FULL;
			end else begin
				slot_used[free_slot] = 1;
				slot_hi[free_slot] = p;
				slot_bud[free_slot] = int'(b);
				r.created_tid = 4'(free_slot);
				if (!run_valid) begin
					if (p) high_insert(free_slot);
					else low_push(free_slot);
					pick_next();
				end else if (!p) begin
					low_push(free_slot);
				end else if (!slot_hi[cur]) begin
					low_push(cur);
					start_thread(free_slot);
					r.event_code = EV_PREEMPT;
				end else if (int'(b) < slot_bud[cur]) begin
					high_insert(cur);
					start_thread(free_slot);
					r.event_code = EV_PREEMPT;
				end else begin
					high_insert(free_slot);
				end
			end
		end else if (o == OP_TICK && run_valid) begin
			if (!slot_hi[cur] && slice_left > 0)
				slice_left--;
			slot_bud[cur]--;
			if (slot_bud[cur] < 0) begin
				slot_used[cur] = 0;
				r.ended_tid = 4'(cur);
				r.event_code = EV_EJECT;
				pick_next();
			end else if (!slot_hi[cur] && slice_left == 0) begin
				low_push(cur);
				r.event_code = EV_QUANTUM;
				pick_next();
			end
		end else if (o == OP_EXIT && run_valid) begin
			slot_used[cur] = 0;
			r.ended_tid = 4'(cur);
			r.event_code = EV_FINISH;
			pick_next();
		end
		if (r.status != ST_FULL && !run_valid)
			r.status = ST_IDLE;
		r.running_valid = run_valid;
		r.running_tid = 4'(run_valid ? run_tid : 0);
		case (r.event_code)
			EV_PREEMPT: n_preempt++;
			EV_EJECT:   n_eject++;
			EV_QUANTUM: n_quantum++;
			default: ;
		endcase
		if (r.status == ST_FULL) n_full++;
		if (r.status == ST_IDLE) n_idle++;
		return r;
	endfunction

	task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_cfg(idx, val);
	endtask

	// waits out outstanding transactions plus the block's own pipeline
	task automatic drain();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_event(logic [1:0] o, logic p, logic [15:0] b, bit typed,
			sched_result_t want);
		sched_result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		priority_req <= p;
		budget_ticks <= b;
		do @(posedge clk); while (!in_ready);
		r = schedule_event(o, p, b);
		pending_results.push_back(typed ? want : r);
		n_events++;
	endtask

	task automatic random_event();
		logic [1:0] o;
		logic [15:0] b;
		int k, w;
		k = $urandom_range(99);
		if (k < 35) o = OP_CREATE;
		else if (k < 82) o = OP_TICK;
		else if (k < 96) o = OP_EXIT;
		else o = 2'd3;
		w = $urandom_range(99);
		if (w < 70) b = 16'($urandom_range(15));
		else if (w < 90) b = 16'($urandom_range(300));
		else if (w < 95) b = 16'hffff;
		else b = 16'($urandom);
		send_event(o, 1'($urandom_range(1)), b, 0, '0);
	endtask

	// result checker
	always @(posedge clk) begin
		sched_result_t got, want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.status = status_t'(status);
				got.created_tid = created_tid;
				got.running_tid = running_tid;
				got.running_valid = running_valid;
				got.event_code = event_t'(event_code);
				got.ended_tid = ended_tid;
				n_results++;
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: %p", got);
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp %p got %p", want, got);
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog expired, %0d results outstanding", pending_results.size());
			$display("FAIL");
			$finish;
		end
	end

	stim_row_t dir_rows[$];

	function automatic stim_row_t row(logic [1:0] o, logic p, logic [15:0] b, bit typed,
			status_t s, logic [3:0] rt, logic rv, event_t e, logic [3:0] et);
		stim_row_t x;
		x.op = o;
		x.prio = p;
		x.budget = b;
		x.typed = typed;
		x.res = '{s, 4'd0, rt, rv, e, et};
		return x;
	endfunction

	initial begin
		int phase_quantum [4] = '{2, 0, 16'hffff, 3};
		int idle_pct [4] = '{0, 81, 0, 8};
		int stall_pct [4] = '{0, 0, 81, 8};
		reset_shadow();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// before any event both writes land in live state
		write_reg(CFG_QUANTUM, 16'd2);
		write_reg(CFG_INIT, 16'd1);

		// thread 0: budget runs out on the same tick the slice ends
		dir_rows.push_back(row(OP_TICK, 0, 0, 1, ST_OK, 0, 1, EV_NONE, 0));
		dir_rows.push_back(row(OP_TICK, 0, 0, 1, ST_IDLE, 0, 0, EV_EJECT, 0));
		dir_rows.push_back(row(OP_TICK, 1, 16'hffff, 1, ST_IDLE, 0, 0, EV_NONE, 0));
		dir_rows.push_back(row(OP_EXIT, 0, 0, 1, ST_IDLE, 0, 0, EV_NONE, 0));
		dir_rows.push_back(row(2'd3, 1, 16'hffff, 1, ST_IDLE, 0, 0, EV_NONE, 0));
		dir_rows.push_back(row(OP_CREATE, 0, 16'hffff, 0, ST_OK, 0, 0, EV_NONE, 0));
		dir_rows.push_back(row(OP_CREATE, 0, 16'h0000, 0, ST_OK, 0, 0, EV_NONE, 0));
		dir_rows.push_back(row(OP_TICK, 0, 0, 0, ST_OK, 0, 0, EV_NONE, 0));
		dir_rows.push_back(row(OP_TICK, 0, 0, 0, ST_OK, 0, 0, EV_NONE, 0));
		dir_rows.push_back(row(OP_TICK, 0, 0, 0, ST_OK, 0, 0, EV_NONE, 0));
		dir_rows.push_back(row(OP_CREATE, 1, 16'd5, 0, ST_OK, 0, 0, EV_NONE, 0));
		dir_rows.push_back(row(OP_CREATE, 1, 16'd5, 0, ST_OK, 0, 0, EV_NONE, 0));
		dir_rows.push_back(row(OP_CREATE, 1, 16'd3, 0, ST_OK, 0, 0, EV_NONE, 0));
		dir_rows.push_back(row(OP_CREATE, 1, 16'd0, 0, ST_OK, 0, 0, EV_NONE, 0));
		dir_rows.push_back(row(OP_TICK, 0, 0, 0, ST_OK, 0, 0, EV_NONE, 0));
		dir_rows.push_back(row(OP_EXIT, 0, 0, 0, ST_OK, 0, 0, EV_NONE, 0));
		dir_rows.push_back(row(OP_CREATE, 1, 16'hffff, 0, ST_OK, 0, 0, EV_NONE, 0));
		dir_rows.push_back(row(2'd3, 0, 16'haaaa, 0, ST_OK, 0, 0, EV_NONE, 0));
		dir_rows.push_back(row(OP_TICK, 0, 0, 0, ST_OK, 0, 0, EV_NONE, 0));
		dir_rows.push_back(row(OP_EXIT, 0, 0, 0, ST_OK, 0, 0, EV_NONE, 0));
		foreach (dir_rows[i])
			send_event(dir_rows[i].op, dir_rows[i].prio, dir_rows[i].budget,
				dir_rows[i].typed, dir_rows[i].res);

		for (int ph = 0; ph < 4; ph++) begin
			in_valid <= 1'b0;
			drain();
			write_reg(CFG_QUANTUM, 16'(phase_quantum[ph]));
			if (ph == 1) write_reg(CFG_INIT, 16'hffff);
			if (ph == 3) write_reg(CFG_INIT, 16'h0000);
			send_idle_pct = idle_pct[ph];
			recv_stall_pct = stall_pct[ph];
			for (int n = 0; n < 245; n++) begin
				if (ph == 0 && n == 120) begin
					in_valid <= 1'b0;
					while (pending_results.size() != 0)
						@(posedge clk);
				end
				random_event();
			end
		end
		in_valid <= 1'b0;
		drain();
		repeat (10) @(posedge clk);
		$display("%0d events, %0d results; %0d preemptions, %0d ejections, %0d slice switches",
			n_events, n_results, n_preempt, n_eject, n_quantum);
		$display("%0d full-table creates, %0d idle results, quanta 2/0/65535/3, %0d mismatches",
			n_full, n_idle, mismatches);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
